[rtl/pva_pkg.sv]
package pva_pkg;

  localparam int VOICES_DEF = 16;

  localparam logic [8:0] UNITY_GAIN = 9'd256;
  localparam logic [16:0] LEVEL_MAX = 17'd128;
  localparam logic [25:0] ROUND_HALF = 26'd256;

  localparam logic [1:0] OP_PLAY  = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_LOW   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0]  width;
    logic [7:0]  level;
    logic [15:0] key;
    logic [31:0] end_ms;
  } entry_t;

  typedef enum logic [2:0] {
    M_HOLD,
    M_COMPACT,
    M_INSERT,
    M_ROTATE,
    M_STOP
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] now;
    logic [15:0] key;
    entry_t      newv;
  } cmd_t;

endpackage

[rtl/pva_cell.sv]
module pva_cell (
  input  logic           clk,
  input  pva_pkg::cmd_t  cmd,
  input  logic           occ,
  input  pva_pkg::entry_t left,
  input  pva_pkg::entry_t right,
  input  logic           chain_in,
  output pva_pkg::entry_t ent,
  output logic           live,
  output logic           chain_out,
  output logic           mark
);

  pva_pkg::entry_t ent_next;
  logic below;
  logic dead;
  logic keyhit;

  always_comb begin
    live   = cmd.now < ent.end_ms;
    below  = occ && (cmd.newv.width < ent.width || cmd.newv.level < ent.level);
    dead   = occ && !live;
    keyhit = ent.key == cmd.key;
    ent_next  = ent;
    chain_out = chain_in;
    mark      = 1'b0;
    case (cmd.mode)
      pva_pkg::M_COMPACT: begin
        // first retired voice and everything after it moves one place down
        chain_out = chain_in | dead;
        mark      = dead;
        if (chain_in | dead) begin
          ent_next = right;
        end
      end
      pva_pkg::M_INSERT: begin
        chain_out = chain_in | !below;
        mark      = !below && !chain_in;
        if (chain_in) begin
          ent_next = left;
        end else if (!below) begin
          ent_next = cmd.newv;
        end
      end
      pva_pkg::M_ROTATE: begin
        ent_next = right;
      end
      pva_pkg::M_STOP: begin
        if (keyhit) begin
          ent_next.key    = '1;
          ent_next.end_ms = '0;
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

[rtl/priority_voice_allocator_unit.sv]
// Voice allocator: a row of VOICES cells holds the voice table in rank order.
// An item is taken when start is high and busy is low; its single result is
// shown for exactly one cycle with done high, and the receiver cannot stall
// it, so it must be sampled in that cycle. Stop-by-key, clear, empty plays
// and counts with a negative key answer in the cycle after they are taken. A
// play first compacts: the row closes one gap per cycle until it sees that
// no gap is left; then it inserts. A count rotates the table once through
// the row, and each entry is checked at its head. master_gain may be
// written on the cfg port at any cycle the block is idle; cfg_ready is
// always high.
module priority_voice_allocator_unit #(
  parameter int VOICES = pva_pkg::VOICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] voice_key,
  input  logic [7:0]         rank_width,
  input  logic [15:0]        gain,
  input  logic [15:0]        span_ms,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [3:0]         slot,
  output logic               evicted,
  output logic [4:0]         live_count
);

  localparam int CW = $clog2(VOICES + 1);
  localparam int IW = $clog2(VOICES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_INSERT,
    S_COUNT
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [8:0]      master;
  logic [31:0]     now_r;
  logic [15:0]     key_r;
  logic [7:0]      width_r;
  logic [31:0]     end_r;
  logic [24:0]     prod_r;
  logic [7:0]      lvl_r;
  logic [IW-1:0]   j;
  logic [CW-1:0]   tally;

  pva_pkg::cmd_t   cmd;
  pva_pkg::entry_t ents [VOICES];
  logic [VOICES:0]   chain;
  logic [VOICES-1:0] live;
  logic [VOICES-1:0] mark;
  logic [VOICES-1:0] occ;

  logic            accept;
  logic [8:0]      m;
  logic [24:0]     prod_w;
  logic [32:0]     end_sum;
  logic [31:0]     end_sat;
  logic [7:0]      width_cl;
  logic [25:0]     lvl_sum;
  logic [16:0]     lvl_q;
  logic [7:0]      lvl_calc;
  logic [IW-1:0]   idx;
  logic [31:0]     idx_ext;
  logic            full;
  logic            hit;
  logic [CW-1:0]   tally_next;
  logic [31:0]     tally_ext;

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign m        = (master > pva_pkg::UNITY_GAIN) ? pva_pkg::UNITY_GAIN : master;
  assign prod_w   = {9'b0, gain} * {16'b0, m};
  assign end_sum  = {1'b0, now_ms} + {17'b0, span_ms};
  assign end_sat  = end_sum[32] ? '1 : end_sum[31:0];
  assign width_cl = (rank_width == 8'd0) ? 8'd1 : rank_width;
  assign lvl_sum  = {1'b0, prod_r} + pva_pkg::ROUND_HALF;
  assign lvl_q    = lvl_sum[25:9];
  assign lvl_calc = (lvl_q > pva_pkg::LEVEL_MAX) ? pva_pkg::LEVEL_MAX[7:0] : lvl_q[7:0];

  always_comb begin
    cmd.now  = now_r;
    cmd.key  = (state == S_IDLE) ? voice_key : key_r;
    cmd.newv = '{width: width_r, level: lvl_r, key: key_r, end_ms: end_r};
    case (state)
      S_COMPACT: cmd.mode = pva_pkg::M_COMPACT;
      S_INSERT:  cmd.mode = pva_pkg::M_INSERT;
      S_COUNT:   cmd.mode = pva_pkg::M_ROTATE;
      default: begin
        if (accept && op == pva_pkg::OP_STOP && !voice_key[15]) begin
          cmd.mode = pva_pkg::M_STOP;
        end else begin
          cmd.mode = pva_pkg::M_HOLD;
        end
      end
    endcase
  end

  assign chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < VOICES; g++) begin : g_cell
      pva_pkg::entry_t left_e;
      pva_pkg::entry_t right_e;
      assign occ[g] = CW'(g) < count;
      if (g == 0) begin : g_head
        assign left_e = cmd.newv;
      end else begin : g_mid
        assign left_e = ents[g-1];
      end
      if (g == VOICES - 1) begin : g_tail
        assign right_e = ents[0];
      end else begin : g_body
        assign right_e = ents[g+1];
      end
      pva_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (occ[g]),
        .left      (left_e),
        .right     (right_e),
        .chain_in  (chain[g]),
        .ent       (ents[g]),
        .live      (live[g]),
        .chain_out (chain[g+1]),
        .mark      (mark[g])
      );
    end
  endgenerate

  always_comb begin
    idx = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (mark[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign idx_ext    = 32'(idx);
  assign full       = count == CW'(VOICES);
  assign hit        = (ents[0].key == key_r) && live[0] && (CW'(j) < count);
  assign tally_next = tally + CW'(hit);
  assign tally_ext  = 32'(tally_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      master     <= pva_pkg::UNITY_GAIN;
      done       <= 1'b0;
      status     <= pva_pkg::ST_DONE;
      slot       <= '0;
      evicted    <= 1'b0;
      live_count <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        master <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            status     <= pva_pkg::ST_DONE;
            slot       <= '0;
            evicted    <= 1'b0;
            live_count <= '0;
            now_r      <= now_ms;
            key_r      <= voice_key;
            width_r    <= width_cl;
            end_r      <= end_sat;
            prod_r     <= prod_w;
            case (op)
              pva_pkg::OP_PLAY: begin
                if (span_ms == 16'd0) begin
                  done   <= 1'b1;
                  status <= pva_pkg::ST_EMPTY;
                end else begin
                  state <= S_COMPACT;
                end
              end
              pva_pkg::OP_COUNT: begin
                if (voice_key[15]) begin
                  done <= 1'b1;
                end else begin
                  j     <= '0;
                  tally <= '0;
                  state <= S_COUNT;
                end
              end
              pva_pkg::OP_STOP: begin
                done <= 1'b1;
              end
              default: begin
                count <= '0;
                done  <= 1'b1;
              end
            endcase
          end
        end
        S_COMPACT: begin
          lvl_r <= lvl_calc;
          if (chain[VOICES]) begin
            count <= count - CW'(1);
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (full && !chain[VOICES]) begin
            status <= pva_pkg::ST_LOW;
          end else begin
            slot    <= idx_ext[3:0];
            evicted <= full;
            if (!full) begin
              count <= count + CW'(1);
            end
          end
        end
        S_COUNT: begin
          tally <= tally_next;
          if (j == IW'(VOICES - 1)) begin
            done       <= 1'b1;
            live_count <= tally_ext[4:0];
            state      <= S_IDLE;
          end else begin
            j <= j + IW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(VOICES))
    else $error("voice count above table size");

  a_empty_play: assert property (@(posedge clk) disable iff (rst)
    accept && op == pva_pkg::OP_PLAY && span_ms == 16'd0
    |=> done && status == pva_pkg::ST_EMPTY)
    else $error("empty sound not rejected at once");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    done && status == pva_pkg::ST_LOW |-> full)
    else $error("low priority reject with room in table");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> status == pva_pkg::ST_DONE && full)
    else $error("eviction without a successful insert");

endmodule
